>>> sv/mrhm_pkg.sv
`timescale 1ns / 1ps

package mrhm_pkg;

  localparam int FRAME_BYTES_DEF = 256;

  // Width used for position and length compares; holds any frame length up to 256 bytes
  // and the longest expected length of five plus twice 125.
  localparam int CMP_W = 10;

  localparam logic [1:0] CMD_REQ  = 2'd0;
  localparam logic [1:0] CMD_BYTE = 2'd1;
  localparam logic [1:0] CMD_EOF  = 2'd2;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_RESP   = 3'd1;
  localparam logic [2:0] ST_CRC_ERR   = 3'd2;
  localparam logic [2:0] ST_EXCEPTION = 3'd3;
  localparam logic [2:0] ST_BAD_COUNT = 3'd4;
  localparam logic [2:0] ST_SHORT     = 3'd5;

  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  FUNC_EXC_BIT      = 8'h80;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;

  typedef struct packed {
    logic        has_res;
    logic        is_req;
    logic [1:0]  kind;
    logic [6:0]  word_index;
    logic [15:0] word_value;
    logic [2:0]  status;
    logic [7:0]  exception_code;
    logic [7:0]  slave_addr;
    logic [15:0] first_register;
    logic [6:0]  register_count;
  } res_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> sv/mrhm_rx.sv
`timescale 1ns / 1ps

module mrhm_rx #(
  parameter int FRAME_BYTES = mrhm_pkg::FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [1:0]        cmd,
  input  logic [7:0]        slave_addr,
  input  logic [15:0]       first_register,
  input  logic [6:0]        register_count,
  input  logic [7:0]        rx_data,
  input  logic              advance,
  output mrhm_pkg::res_t    res
);
  import mrhm_pkg::*;

  localparam int POS_W = $clog2(FRAME_BYTES + 1);

  logic [6:0]       exp_regs_r, exp_regs_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [7:0]       cnt_byte_r, cnt_byte_nxt;
  logic [7:0]       pend_r, pend_nxt;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] need_len;
  logic             full;
  logic             is_word;
  logic             word_ok;

  assign pos_ext  = {{(CMP_W - POS_W){1'b0}}, pos_r};
  assign full     = pos_ext >= CMP_W'(FRAME_BYTES);
  assign idx_ext  = (pos_ext - CMP_W'(4)) >> 1;
  assign is_word  = (pos_ext >= CMP_W'(4)) && !pos_ext[0];
  assign word_ok  = is_word && (idx_ext < CMP_W'(exp_regs_r));
  assign need_len = CMP_W'(5) + CMP_W'({exp_regs_r, 1'b0});

  always_comb begin
    res          = '0;
    exp_regs_nxt = exp_regs_r;
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    func_nxt     = func_r;
    cnt_byte_nxt = cnt_byte_r;
    pend_nxt     = pend_r;
    if (in_vld) begin
      unique case (cmd)
        CMD_REQ: begin
          res.has_res        = 1'b1;
          res.is_req         = 1'b1;
          res.kind           = KIND_TX;
          res.slave_addr     = slave_addr;
          res.first_register = first_register;
          res.register_count = register_count;
          exp_regs_nxt       = register_count;
          pos_nxt            = '0;
          crc_nxt            = CRC_INIT;
          func_nxt           = '0;
          cnt_byte_nxt       = '0;
          pend_nxt           = '0;
        end
        CMD_BYTE: begin
          if (!full) begin
            crc_nxt = crc_feed(crc_r, rx_data);
            pos_nxt = pos_r + POS_W'(1);
            if (pos_ext == CMP_W'(1)) begin
              func_nxt = rx_data;
            end else if (pos_ext == CMP_W'(2)) begin
              cnt_byte_nxt = rx_data;
            end else if (pos_ext >= CMP_W'(3) && pos_ext[0]) begin
              pend_nxt = rx_data;
            end else if (word_ok) begin
              res.has_res    = 1'b1;
              res.kind       = KIND_WORD;
              res.word_index = idx_ext[6:0];
              res.word_value = {pend_r, rx_data};
            end
          end
        end
        CMD_EOF: begin
          res.has_res = 1'b1;
          res.kind    = KIND_STATUS;
          if (pos_ext < CMP_W'(5)) begin
            res.status = ST_NO_RESP;
          end else if (crc_r != 16'h0000) begin
            res.status = ST_CRC_ERR;
          end else if ((func_r & FUNC_EXC_BIT) != 8'h00) begin
            res.status         = ST_EXCEPTION;
            res.exception_code = cnt_byte_r;
          end else if (cnt_byte_r != {exp_regs_r, 1'b0}) begin
            res.status = ST_BAD_COUNT;
          end else if (pos_ext < need_len) begin
            res.status = ST_SHORT;
          end else begin
            res.status = ST_OK;
          end
          pos_nxt      = '0;
          crc_nxt      = CRC_INIT;
          func_nxt     = '0;
          cnt_byte_nxt = '0;
          pend_nxt     = '0;
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_regs_r <= '0;
      pos_r      <= '0;
      crc_r      <= CRC_INIT;
      func_r     <= '0;
      cnt_byte_r <= '0;
      pend_r     <= '0;
    end else if (advance) begin
      exp_regs_r <= exp_regs_nxt;
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      func_r     <= func_nxt;
      cnt_byte_r <= cnt_byte_nxt;
      pend_r     <= pend_nxt;
    end
  end

endmodule

>>> sv/mrhm_out.sv
`timescale 1ns / 1ps

module mrhm_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  mrhm_pkg::res_t    res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_tx_data,
  output logic [6:0]        out_word_index,
  output logic [15:0]       out_word_value,
  output logic [2:0]        out_status,
  output logic [7:0]        out_exception_code,
  output logic              out_last
);
  import mrhm_pkg::*;

  logic        vld_r, vld_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  tx_r, tx_nxt;
  logic [6:0]  idx_r, idx_nxt;
  logic [15:0] val_r, val_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [7:0]  exc_r, exc_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  seq_r, seq_nxt;
  logic [15:0] first_r, first_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_fed;
  logic        take;

  assign take    = vld_r && !out_stall;
  assign free    = !vld_r || (take && last_r);
  assign crc_fed = crc_feed(crc_r, tx_r);

  always_comb begin
    vld_nxt   = vld_r;
    kind_nxt  = kind_r;
    tx_nxt    = tx_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    st_nxt    = st_r;
    exc_nxt   = exc_r;
    last_nxt  = last_r;
    seq_nxt   = seq_r;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    if (take && !last_r) begin
      // Request frame in progress: step to the next byte. The CRC takes in
      // each byte as it leaves, so it is complete once the count byte is gone.
      seq_nxt  = seq_r + 3'd1;
      last_nxt = (seq_r == 3'd6);
      if (seq_r <= 3'd5) begin
        crc_nxt = crc_fed;
      end
      case (seq_r)
        3'd0:    tx_nxt = FUNC_READ_HOLDING;
        3'd1:    tx_nxt = first_r[15:8];
        3'd2:    tx_nxt = first_r[7:0];
        3'd3:    tx_nxt = 8'h00;
        3'd4:    tx_nxt = {1'b0, cnt_r};
        3'd5:    tx_nxt = crc_fed[7:0];
        default: tx_nxt = crc_r[15:8];
      endcase
    end else if (take) begin
      vld_nxt = 1'b0;
    end
    if (load) begin
      vld_nxt   = 1'b1;
      kind_nxt  = res.kind;
      tx_nxt    = res.is_req ? res.slave_addr : 8'h00;
      idx_nxt   = res.word_index;
      val_nxt   = res.word_value;
      st_nxt    = res.status;
      exc_nxt   = res.exception_code;
      last_nxt  = !res.is_req;
      seq_nxt   = '0;
      first_nxt = res.first_register;
      cnt_nxt   = res.register_count;
      crc_nxt   = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    tx_r    <= tx_nxt;
    idx_r   <= idx_nxt;
    val_r   <= val_nxt;
    st_r    <= st_nxt;
    exc_r   <= exc_nxt;
    last_r  <= last_nxt;
    seq_r   <= seq_nxt;
    first_r <= first_nxt;
    cnt_r   <= cnt_nxt;
    crc_r   <= crc_nxt;
  end

  assign out_valid          = vld_r;
  assign out_kind           = kind_r;
  assign out_tx_data        = tx_r;
  assign out_word_index     = idx_r;
  assign out_word_value     = val_r;
  assign out_status         = st_r;
  assign out_exception_code = exc_r;
  assign out_last           = last_r;

endmodule

>>> sv/modbus_read_holding_master.sv
`timescale 1ns / 1ps

// Modbus RTU master for function 3, read holding registers.
// Input channel (in_*): one transaction is a command. A request command yields the eight
// request bytes as transmit results, the last one marked by out_last. A received byte
// yields a register word result when it completes a requested word, else nothing.
// An end-of-frame command yields one status result and clears the receive side.
// Output channel (out_*): one result per transaction, the fields that do not apply are zero.
// A command is first registered in the input register; its result is then loaded into the
// output register, which drives out_valid, once that register is free.
// Commands with at most one result are taken one per cycle while out_stall is low; a request
// holds the output register until all eight request bytes are taken, while the request
// CRC is accumulated one byte per cycle, when not stalled, in the output sequencer.
// A stall on out_stall holds the current result; the next command that has a result
// then waits in the input register and in_stall rises until the output register frees up.
// Synchronous reset empties both registers and clears the receive state and the
// expected register count.
module modbus_read_holding_master #(
  parameter int FRAME_BYTES = mrhm_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_slave_addr,
  input  logic [15:0] in_first_register,
  input  logic [6:0]  in_register_count,
  input  logic [7:0]  in_rx_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_data,
  output logic [6:0]  out_word_index,
  output logic [15:0] out_word_value,
  output logic [2:0]  out_status,
  output logic [7:0]  out_exception_code,
  output logic        out_last
);
  import mrhm_pkg::*;

  logic        in_vld_r;
  logic [1:0]  cmd_r;
  logic [7:0]  slave_r;
  logic [15:0] first_r;
  logic [6:0]  count_r;
  logic [7:0]  data_r;
  logic        advance;
  logic        out_free;
  res_t        res;

  assign advance  = in_vld_r && (!res.has_res || out_free);
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r   <= in_cmd;
      slave_r <= in_slave_addr;
      first_r <= in_first_register;
      count_r <= in_register_count;
      data_r  <= in_rx_data;
    end
  end

  mrhm_rx #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_rx (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_vld         (in_vld_r),
    .cmd            (cmd_r),
    .slave_addr     (slave_r),
    .first_register (first_r),
    .register_count (count_r),
    .rx_data        (data_r),
    .advance        (advance),
    .res            (res)
  );

  mrhm_out u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (advance && res.has_res),
    .res                (res),
    .free               (out_free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_tx_data        (out_tx_data),
    .out_word_index     (out_word_index),
    .out_word_value     (out_word_value),
    .out_status         (out_status),
    .out_exception_code (out_exception_code),
    .out_last           (out_last)
  );

endmodule

>>> sv/mrhm_chk.sv
`timescale 1ns / 1ps

module mrhm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_tx_data,
  input logic [2:0]  out_status,
  input logic        out_last
);
  import mrhm_pkg::*;

  // The output register is empty on the first cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result present right after reset");

  // Status and word transactions each end their run.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_STATUS || out_kind == KIND_WORD)) |-> out_last)
    else $error("status or word result without last");

  // Word results always carry status ok.
  a_word_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_WORD) |-> (out_status == ST_OK))
    else $error("word result with nonzero status");

  // A request frame goes out without gaps once its first byte is taken.
  a_tx_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_kind == KIND_TX && !out_last)
      |=> (out_valid && out_kind == KIND_TX))
    else $error("request frame interrupted");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_tx_data)))
    else $error("stalled result changed");

endmodule

bind modbus_read_holding_master mrhm_chk u_mrhm_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_kind    (out_kind),
  .out_tx_data (out_tx_data),
  .out_status  (out_status),
  .out_last    (out_last)
);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import mrhm_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int FRAME_LIMIT = FRAME_BYTES_DEF;
  localparam int LONG_HOLD_CYCLES = 80;

  typedef enum logic [1:0] {RX_LIT, RX_CRC_LO, RX_CRC_HI} rx_src_t;
  typedef enum int {
    RESP_OK, RESP_EXCEPTION, RESP_BAD_COUNT, RESP_SHORT, RESP_CORRUPT, RESP_TRUNCATED
  } resp_shape_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  slave;
    logic [15:0] first;
    logic [6:0]  count;
    logic [7:0]  rx;
    rx_src_t     src;
    logic        typed;
    logic [2:0]  st;
    logic [7:0]  exc;
  } stim_row_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_data;
    logic [6:0]  word_index;
    logic [15:0] word_value;
    logic [2:0]  status;
    logic [7:0]  exception_code;
    logic        last;
  } master_result_t;

  // Rows with typed set carry their final status here; the rest go through the predictor.
  // CRC rows take the running frame CRC, so the frame closes with a zero remainder.
  localparam stim_row_t DIRECTED [24] = '{
    '{CMD_EOF,  8'h00, 16'h0000, 7'd0,   8'h00, RX_LIT,    1'b1, ST_NO_RESP,   8'h00},
    '{CMD_NONE, 8'hA5, 16'h5A5A, 7'd99,  8'hC3, RX_LIT,    1'b0, ST_OK,        8'h00},
    '{CMD_BYTE, 8'h00, 16'h0000, 7'd0,   8'h7F, RX_LIT,    1'b0, ST_OK,        8'h00},
    '{CMD_BYTE, 8'h00, 16'h0000, 7'd0,   8'h80, RX_LIT,    1'b0, ST_OK,        8'h00},
    '{CMD_EOF,  8'h00, 16'h0000, 7'd0,   8'h00, RX_LIT,    1'b1, ST_NO_RESP,   8'h00},
    '{CMD_REQ,  8'hFF, 16'hFFFF, 7'd125, 8'hFF, RX_LIT,    1'b0, ST_OK,        8'h00},
    '{CMD_REQ,  8'h00, 16'h0000, 7'd0,   8'h00, RX_LIT,    1'b0, ST_OK,        8'h00},
    '{CMD_REQ,  8'h01, 16'h1234, 7'd1,   8'h00, RX_LIT,    1'b0, ST_OK,        8'h00},
    '{CMD_BYTE, 8'h00, 16'h0000, 7'd0,   8'h01, RX_LIT,    1'b0, ST_OK,        8'h00},
    '{CMD_BYTE, 8'h00, 16'h0000, 7'd0,   8'h03, RX_LIT,    1'b0, ST_OK,        8'h00},
    '{CMD_BYTE, 8'h00, 16'h0000, 7'd0,   8'h02, RX_LIT,    1'b0, ST_OK,        8'h00},
    '{CMD_BYTE, 8'h00, 16'h0000, 7'd0,   8'hFF, RX_LIT,    1'b0, ST_OK,        8'h00},
    '{CMD_BYTE, 8'h00, 16'h0000, 7'd0,   8'hFF, RX_LIT,    1'b0, ST_OK,        8'h00},
    '{CMD_BYTE, 8'h00, 16'h0000, 7'd0,   8'h00, RX_CRC_LO, 1'b0, ST_OK,        8'h00},
    '{CMD_BYTE, 8'h00, 16'h0000, 7'd0,   8'h00, RX_CRC_HI, 1'b0, ST_OK,        8'h00},
    '{CMD_EOF,  8'h00, 16'h0000, 7'd0,   8'h00, RX_LIT,    1'b1, ST_OK,        8'h00},
    '{CMD_BYTE, 8'h00, 16'h0000, 7'd0,   8'h01, RX_LIT,    1'b0, ST_OK,        8'h00},
    '{CMD_BYTE, 8'h00, 16'h0000, 7'd0,   8'h83, RX_LIT,    1'b0, ST_OK,        8'h00},
    '{CMD_BYTE, 8'h00, 16'h0000, 7'd0,   8'h02, RX_LIT,    1'b0, ST_OK,        8'h00},
    '{CMD_BYTE, 8'h00, 16'h0000, 7'd0,   8'h00, RX_CRC_LO, 1'b0, ST_OK,        8'h00},
    '{CMD_BYTE, 8'h00, 16'h0000, 7'd0,   8'h00, RX_CRC_HI, 1'b0, ST_OK,        8'h00},
    '{CMD_EOF,  8'h00, 16'h0000, 7'd0,   8'h00, RX_LIT,    1'b1, ST_EXCEPTION, 8'h02},
    '{CMD_BYTE, 8'h00, 16'h0000, 7'd0,   8'h01, RX_LIT,    1'b0, ST_OK,        8'h00},
    '{CMD_REQ,  8'h11, 16'h0001, 7'd3,   8'h00, RX_LIT,    1'b0, ST_OK,        8'h00}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [7:0]  in_slave_addr;
  logic [15:0] in_first_register;
  logic [6:0]  in_register_count;
  logic [7:0]  in_rx_data;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [7:0]  out_tx_data;
  logic [6:0]  out_word_index;
  logic [15:0] out_word_value;
  logic [2:0]  out_status;
  logic [7:0]  out_exception_code;
  logic        out_last;

  modbus_read_holding_master dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_slave_addr      (in_slave_addr),
    .in_first_register  (in_first_register),
    .in_register_count  (in_register_count),
    .in_rx_data         (in_rx_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_tx_data        (out_tx_data),
    .out_word_index     (out_word_index),
    .out_word_value     (out_word_value),
    .out_status         (out_status),
    .out_exception_code (out_exception_code),
    .out_last           (out_last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Predicted master state.
  logic [6:0]  awaited_regs = 7'd0;
  int          frame_len = 0;
  logic [15:0] frame_crc = CRC_INIT;
  logic [7:0]  frame_func = 8'h00;
  logic [7:0]  frame_bytecount = 8'h00;
  logic [7:0]  word_hi = 8'h00;

  master_result_t awaited[$];
  int  fails = 0;
  int  items_sent = 0;
  int  hold_requests = 0;
  bit  gaps_on = 1'b0;
  bit  stall_on = 1'b0;

  function automatic logic [15:0] crc16_modbus(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] c;
    c = acc ^ {8'h00, data};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void push_result(input logic [1:0] kind, input logic [7:0] tx,
                                      input logic [6:0] idx, input logic [15:0] val,
                                      input logic [2:0] st, input logic [7:0] exc,
                                      input logic last);
    master_result_t res;
    res = '{kind, tx, idx, val, st, exc, last};
    awaited.push_back(res);
  endfunction

  function automatic void clear_frame();
    frame_len = 0;
    frame_crc = CRC_INIT;
    frame_func = 8'h00;
    frame_bytecount = 8'h00;
    word_hi = 8'h00;
  endfunction

  function automatic void predict_master(input stim_row_t r);
    logic [7:0]  req_b [8];
    logic [15:0] c;
    logic [2:0]  st;
    logic [7:0]  exc;
    int          idx;
    case (r.cmd)
      CMD_REQ: begin
        req_b[0] = r.slave;
        req_b[1] = FUNC_READ_HOLDING;
        req_b[2] = r.first[15:8];
        req_b[3] = r.first[7:0];
        req_b[4] = 8'h00;
        req_b[5] = {1'b0, r.count};
        c = CRC_INIT;
        for (int i = 0; i < 6; i++) c = crc16_modbus(c, req_b[i]);
        req_b[6] = c[7:0];
        req_b[7] = c[15:8];
        awaited_regs = r.count;
        clear_frame();
        for (int i = 0; i < 8; i++) begin
          push_result(KIND_TX, req_b[i], 7'd0, 16'h0000, ST_OK, 8'h00, i == 7);
        end
      end
      CMD_BYTE: begin
        // Bytes past the frame buffer leave no trace at all.
        if (frame_len < FRAME_LIMIT) begin
          frame_crc = crc16_modbus(frame_crc, r.rx);
          if (frame_len == 1) begin
            frame_func = r.rx;
          end else if (frame_len == 2) begin
            frame_bytecount = r.rx;
          end else if (frame_len >= 3) begin
            if (frame_len % 2 == 1) begin
              word_hi = r.rx;
            end else begin
              idx = (frame_len - 4) / 2;
              if (idx < awaited_regs) begin
                push_result(KIND_WORD, 8'h00, 7'(idx), {word_hi, r.rx}, ST_OK, 8'h00, 1'b1);
              end
            end
          end
          frame_len++;
        end
      end
      CMD_EOF: begin
        exc = 8'h00;
        if (frame_len < 5) begin
          st = ST_NO_RESP;
        end else if (frame_crc != 16'h0000) begin
          st = ST_CRC_ERR;
        end else if ((frame_func & FUNC_EXC_BIT) != 8'h00) begin
          st = ST_EXCEPTION;
          exc = frame_bytecount;
        end else if (int'(frame_bytecount) != 2 * int'(awaited_regs)) begin
          st = ST_BAD_COUNT;
        end else if (frame_len < 5 + 2 * int'(awaited_regs)) begin
          st = ST_SHORT;
        end else begin
          st = ST_OK;
        end
        push_result(KIND_STATUS, 8'h00, 7'd0, 16'h0000, st, exc, 1'b1);
        clear_frame();
      end
      default: ;
    endcase
  endfunction

  function automatic stim_row_t random_row(input logic [1:0] cmd);
    stim_row_t r;
    r.cmd = cmd;
    r.slave = 8'($urandom);
    r.first = 16'($urandom);
    r.count = 7'($urandom_range(0, 125));
    r.rx = 8'($urandom);
    r.src = RX_LIT;
    r.typed = 1'b0;
    r.st = ST_OK;
    r.exc = 8'h00;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input stim_row_t r);
    int before_n;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= r.cmd;
    in_slave_addr <= r.slave;
    in_first_register <= r.first;
    in_register_count <= r.count;
    in_rx_data <= r.rx;
    before_n = awaited.size();
    predict_master(r);
    if (r.typed) begin
      while (awaited.size() > before_n) void'(awaited.pop_back());
      push_result(KIND_STATUS, 8'h00, 7'd0, 16'h0000, r.st, r.exc, 1'b1);
    end
    do @(posedge clk); while (in_stall);
    if (r.cmd != CMD_NONE) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_req(input logic [7:0] slave, input logic [6:0] cnt);
    stim_row_t r;
    r = random_row(CMD_REQ);
    r.slave = slave;
    r.count = cnt;
    send_item(r);
  endtask

  task automatic send_byte(input logic [7:0] b);
    stim_row_t r;
    r = random_row(CMD_BYTE);
    r.rx = b;
    send_item(r);
  endtask

  task automatic send_eof();
    send_item(random_row(CMD_EOF));
  endtask

  // Builds a response frame of the given shape for a request of cnt registers and sends it.
  task automatic send_frame(input logic [7:0] slave, input int cnt, input resp_shape_t shape);
    logic [7:0]  frame[$];
    logic [15:0] c;
    int          keep;
    int          pos;
    frame.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : slave);
    if (shape == RESP_EXCEPTION) begin
      frame.push_back(FUNC_EXC_BIT | 8'($urandom_range(0, 127)));
      frame.push_back(8'($urandom));
    end else begin
      frame.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 127))
                                                  : FUNC_READ_HOLDING);
      if (shape == RESP_BAD_COUNT) begin
        frame.push_back(8'(2 * cnt) ^ (8'd1 << $urandom_range(0, 7)));
      end else begin
        frame.push_back(8'(2 * cnt));
      end
      keep = (shape == RESP_SHORT && cnt > 0) ? $urandom_range(0, 2 * cnt - 1) : 2 * cnt;
      repeat (keep) frame.push_back(8'($urandom));
    end
    c = CRC_INIT;
    foreach (frame[i]) c = crc16_modbus(c, frame[i]);
    frame.push_back(c[7:0]);
    frame.push_back(c[15:8]);
    if (shape == RESP_CORRUPT) begin
      pos = $urandom_range(0, frame.size() - 1);
      frame[pos] ^= 8'd1 << $urandom_range(0, 7);
    end else if (shape == RESP_TRUNCATED) begin
      keep = $urandom_range(0, 4);
      while (frame.size() > keep) void'(frame.pop_back());
    end else if (shape == RESP_OK && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
    end
    foreach (frame[i]) send_byte(frame[i]);
  endtask

  task automatic random_exchange();
    logic [7:0] slave;
    int         cnt;
    int         pick;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) send_item(random_row(2'($urandom_range(0, 3))));
    end else begin
      cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
      slave = 8'($urandom);
      send_req(slave, 7'(cnt));
      pick = $urandom_range(0, 9);
      send_frame(slave, cnt, resp_shape_t'((pick < 5) ? 0 : pick - 4));
      // Now and then the frame is left open and the next request cuts it off.
      if ($urandom_range(0, 11) != 0) send_eof();
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited.size() != 0);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : check_results
    master_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        $error("result with none pending: kind %0d", out_kind);
        fails++;
      end else begin
        want = awaited.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("tx_data", want.tx_data, out_tx_data);
        check_field("word_index", want.word_index, out_word_index);
        check_field("word_value", want.word_value, out_word_value);
        check_field("status", want.status, out_status);
        check_field("exception_code", want.exception_code, out_exception_code);
        check_field("last", want.last, out_last);
      end
    end
  end

  initial begin : receiver
    int holds_done;
    int n;
    holds_done = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    stim_row_t   r;
    logic [15:0] crc_hold;
    logic [7:0]  slave;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_NONE;
    in_slave_addr = 8'h00;
    in_first_register = 16'h0000;
    in_register_count = 7'd0;
    in_rx_data = 8'h00;
    crc_hold = CRC_INIT;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    gaps_on = 1'b1;
    stall_on = 1'b1;

    foreach (DIRECTED[i]) begin
      r = DIRECTED[i];
      if (r.src == RX_CRC_LO) begin
        crc_hold = frame_crc;
        r.rx = crc_hold[7:0];
      end else if (r.src == RX_CRC_HI) begin
        r.rx = crc_hold[15:8];
      end
      send_item(r);
    end
    wait_drained();

    while (items_sent < 130) random_exchange();

    // The receiver holds off while the sender keeps offering transactions back to back.
    hold_requests++;
    gaps_on = 1'b0;
    slave = 8'($urandom);
    send_req(slave, 7'd4);
    send_frame(slave, 4, RESP_OK);
    send_eof();
    gaps_on = 1'b1;
    wait_drained();

    // Largest request, then bytes running past the end of the frame buffer.
    slave = 8'($urandom);
    send_req(slave, 7'd125);
    send_frame(slave, 125, RESP_OK);
    repeat (FRAME_LIMIT + 3 - frame_len) send_byte(8'($urandom));
    send_eof();

    while (items_sent < 440) random_exchange();
    gaps_on = 1'b0;
    stall_on = 1'b0;
    while (items_sent < 480) random_exchange();

    in_valid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
